### rtl/cbcc_pkg.sv
// ----------------------------------------------------------------------------
// cbcc_pkg
// Shared widths, types and codes for the circle/box coverage classifier.
// ----------------------------------------------------------------------------
package cbcc_pkg;

   localparam int COORD_W  = 24;
   localparam int DIST_W   = 24;
   localparam int RADIUS_W = 23;
   localparam int SQ_W     = 2 * DIST_W;
   localparam int SUM_W    = SQ_W + 1;
   localparam int R2_W     = 2 * RADIUS_W;
   localparam int REQ_W    = 6 * COORD_W;
   localparam int RSP_W    = 8;

   typedef enum logic [1:0] {
      COV_FULL    = 2'd0,
      COV_NONE    = 2'd1,
      COV_PARTIAL = 2'd2
   } cov_type;

   typedef struct packed {
      logic [DIST_W-1:0] near_x;
      logic [DIST_W-1:0] far_x;
      logic [DIST_W-1:0] near_y;
      logic [DIST_W-1:0] far_y;
   } span_type;

endpackage

### rtl/cbcc_front.sv
// ----------------------------------------------------------------------------
// cbcc_front
// Orders box edges and finds per-axis near and far distances to the point.
// ----------------------------------------------------------------------------
module cbcc_front
   import cbcc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  logic [REQ_W-1:0]   in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output span_type           out_span
);

   logic signed [COORD_W-1:0] qx, qy, xa, xb, ya, yb;
   logic                      adv;

   logic                      s1_valid_ff;
   logic signed [COORD_W-1:0] s1_qx_ff, s1_qy_ff, s1_xl_ff, s1_xh_ff, s1_yl_ff, s1_yh_ff;
   logic signed [COORD_W-1:0] s1_xl_in, s1_xh_in, s1_yl_in, s1_yh_in;

   logic                      s2_valid_ff;
   span_type                  s2_span_ff;
   span_type                  s2_span_in;

   function automatic logic [DIST_W-1:0] abs_diff(input logic signed [COORD_W-1:0] a,
                                                   input logic signed [COORD_W-1:0] b);
      logic signed [COORD_W:0] d;
      d = (a > b) ? ({a[COORD_W-1], a} - {b[COORD_W-1], b})
                  : ({b[COORD_W-1], b} - {a[COORD_W-1], a});
      return d[DIST_W-1:0];
   endfunction

   function automatic void axis_span(input  logic signed [COORD_W-1:0] q,
                                     input  logic signed [COORD_W-1:0] lo,
                                     input  logic signed [COORD_W-1:0] hi,
                                     output logic [DIST_W-1:0]         near_d,
                                     output logic [DIST_W-1:0]         far_d);
      logic [DIST_W-1:0] dl;
      logic [DIST_W-1:0] dh;
      dl = abs_diff(q, lo);
      dh = abs_diff(q, hi);
      if (q < lo) begin
         near_d = dl;
      end else if (q > hi) begin
         near_d = dh;
      end else begin
         near_d = '0;
      end
      far_d = (dl > dh) ? dl : dh;
   endfunction

   assign qx = in_data[0*COORD_W +: COORD_W];
   assign qy = in_data[1*COORD_W +: COORD_W];
   assign xa = in_data[2*COORD_W +: COORD_W];
   assign xb = in_data[3*COORD_W +: COORD_W];
   assign ya = in_data[4*COORD_W +: COORD_W];
   assign yb = in_data[5*COORD_W +: COORD_W];

   assign adv      = !s2_valid_ff || out_ready;
   assign in_ready = adv;

   // order the edges
   always_comb begin
      s1_xl_in = (xa > xb) ? xb : xa;
      s1_xh_in = (xa > xb) ? xa : xb;
      s1_yl_in = (ya > yb) ? yb : ya;
      s1_yh_in = (ya > yb) ? ya : yb;
   end

   always_comb begin
      axis_span(s1_qx_ff, s1_xl_ff, s1_xh_ff, s2_span_in.near_x, s2_span_in.far_x);
      axis_span(s1_qy_ff, s1_yl_ff, s1_yh_ff, s2_span_in.near_y, s2_span_in.far_y);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_qx_ff   <= qx;
         s1_qy_ff   <= qy;
         s1_xl_ff   <= s1_xl_in;
         s1_xh_ff   <= s1_xh_in;
         s1_yl_ff   <= s1_yl_in;
         s1_yh_ff   <= s1_yh_in;
         s2_span_ff <= s2_span_in;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_span  = s2_span_ff;

endmodule

### rtl/cbcc_queue.sv
// ----------------------------------------------------------------------------
// cbcc_queue
// Four-entry queue of span records between the front and back parts.
// ----------------------------------------------------------------------------
module cbcc_queue
   import cbcc_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   output logic     push_ready,
   input  span_type push_span,
   output logic     pop_valid,
   input  logic     pop_ready,
   output span_type pop_span
);

   localparam int DEPTH = 4;
   localparam int IDX_W = $clog2(DEPTH);

   span_type           mem [DEPTH];
   logic [IDX_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [IDX_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [IDX_W:0]     count_ff, count_in;
   logic               push, pop;

   assign push_ready = (count_ff != (IDX_W+1)'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_span   = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_span;
      end
   end

endmodule

### rtl/cbcc_back.sv
// ----------------------------------------------------------------------------
// cbcc_back
// Squares the spans, sums them and classifies against the squared radius.
// ----------------------------------------------------------------------------
module cbcc_back
   import cbcc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic [RADIUS_W-1:0] radius,
   input  logic                in_valid,
   output logic                in_ready,
   input  span_type            in_span,
   output logic                out_valid,
   input  logic                out_ready,
   output cov_type             out_cov
);

   logic              adv;
   logic [R2_W-1:0]   r2_ff;

   logic              b1_valid_ff;
   logic [SQ_W-1:0]   nx2_ff, fx2_ff, ny2_ff, fy2_ff;

   logic              b2_valid_ff;
   logic [SUM_W-1:0]  near2_ff, far2_ff;

   logic              out_valid_ff;
   cov_type           cov_ff, cov_in;

   assign adv      = !out_valid_ff || out_ready;
   assign in_ready = adv;

   always_comb begin
      if (far2_ff < SUM_W'(r2_ff)) begin
         cov_in = COV_FULL;
      end else if (near2_ff > SUM_W'(r2_ff)) begin
         cov_in = COV_NONE;
      end else begin
         cov_in = COV_PARTIAL;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r2_ff        <= '0;
         b1_valid_ff  <= 1'b0;
         b2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         r2_ff <= R2_W'(radius) * R2_W'(radius);
         if (adv) begin
            b1_valid_ff  <= in_valid;
            b2_valid_ff  <= b1_valid_ff;
            out_valid_ff <= b2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         nx2_ff   <= SQ_W'(in_span.near_x) * SQ_W'(in_span.near_x);
         fx2_ff   <= SQ_W'(in_span.far_x) * SQ_W'(in_span.far_x);
         ny2_ff   <= SQ_W'(in_span.near_y) * SQ_W'(in_span.near_y);
         fy2_ff   <= SQ_W'(in_span.far_y) * SQ_W'(in_span.far_y);
         near2_ff <= SUM_W'(nx2_ff) + SUM_W'(ny2_ff);
         far2_ff  <= SUM_W'(fx2_ff) + SUM_W'(fy2_ff);
         cov_ff   <= cov_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_cov   = cov_ff;

endmodule

### rtl/circle_box_coverage_classify.sv
// ----------------------------------------------------------------------------
// circle_box_coverage_classify
// Classifies an axis-aligned box against a circle around a query point.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one request per handshake: query point and box edges.
//   rsp_* returns one coverage code per request, in order (0 full, 1 none, 2 partial).
//   csr_* writes the circle radius; write it only while no request is in
//   flight. csr_ready is always high.
// Path: an accepted request is loaded into the first of two front stages,
//   then passes the queue and three back stages before rsp_tvalid rises.
// Throughput: one request per cycle while the response side is not stalled,
//   set by the fully pipelined front and back parts; one square unit per span term.
// Reset: synchronous; clears all valid state and sets the radius to zero.
// Stall: when rsp_tready is low the back part holds; the four-entry queue
//   and the front stages keep taking requests until the queue fills, then
//   req_tready drops.
// ----------------------------------------------------------------------------
module circle_box_coverage_classify
   import cbcc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   // query_x, query_y, box_x_a, box_x_b, box_y_a, box_y_b; each edge pair in either order
   input  logic [REQ_W-1:0]    req_tdata,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   // coverage, zero fill
   output logic [RSP_W-1:0]    rsp_tdata,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [RADIUS_W-1:0] csr_wdata
);

   logic [RADIUS_W-1:0] radius_ff;
   logic                fq_valid, fq_ready;
   span_type            fq_span;
   logic                qb_valid, qb_ready;
   span_type            qb_span;
   cov_type             cov;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= '0;
      end else if (csr_valid) begin
         radius_ff <= csr_wdata;
      end
   end

   cbcc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (req_tdata),
      .out_valid (fq_valid),
      .out_ready (fq_ready),
      .out_span  (fq_span)
   );

   cbcc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fq_valid),
      .push_ready (fq_ready),
      .push_span  (fq_span),
      .pop_valid  (qb_valid),
      .pop_ready  (qb_ready),
      .pop_span   (qb_span)
   );

   cbcc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .radius    (radius_ff),
      .in_valid  (qb_valid),
      .in_ready  (qb_ready),
      .in_span   (qb_span),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_cov   (cov)
   );

   assign rsp_tdata = {{(RSP_W-2){1'b0}}, cov};

endmodule
